// File: rtl/assert_macros.svh
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Antecedent holds, consequent must hold on the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/fafc_pkg.sv
`timescale 1ns / 1ps

package fafc_pkg;

    localparam int CAP_W      = 5;
    localparam int APB_ADDR_W = 3;
    localparam int CNT_W      = 32;

    localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;
    localparam logic             REG_CAPACITY = 1'b0;
    localparam logic [CNT_W-1:0] CNT_MAX      = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    typedef struct packed {
        logic load;     // capture the block number
        logic compare;  // register the match vector
        logic update;   // resolve hit/miss, update tags and counters
    } t_dp_cmd;

endpackage

// File: rtl/fifo_fully_assoc_cache_unit.sv
`timescale 1ns / 1ps
// Fully associative block cache with first-in-first-out replacement.
// Access channel: drive i_block_address with start high; the access is taken
// at a clock edge where start is high and busy is low. busy then stays high
// through the tag compare state and the hit/miss resolve and update state.
// Result: o_result_valid pulses for one cycle, from a done flag registered in
// the update state, with o_hit and the saturating running totals o_hit_total and
// o_miss_total. The receiver cannot stall; each result is there one cycle only.
// No new access is taken until the current one has passed the compare stage (all
// tags matched in parallel, match vector registered) and then the update stage.
// A new access can be taken in the cycle its predecessor's result is shown.
// Config: APB register 0 (byte address 0) is capacity, the number of entries in
// use (0 acts as 1, above ENTRIES acts as ENTRIES). Write only while idle.
// Reset (synchronous, active low): no entries filled, pointer and counters
// zero, capacity 16.

module fifo_fully_assoc_cache_unit #(
    parameter int ENTRIES    = 16,
    parameter int BLOCK_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [15:0]                      i_block_address,
    output logic                             o_result_valid,
    output logic                             o_hit,
    output logic [31:0]                      o_hit_total,
    output logic [31:0]                      o_miss_total,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fafc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int KEY_W = (BLOCK_BITS < 16) ? BLOCK_BITS : 16;

    logic [fafc_pkg::CAP_W-1:0] r_capacity;
    logic                       cfg_wr;
    fafc_pkg::t_dp_cmd          cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= fafc_pkg::CAP_RESET;
        end else if (cfg_wr && (paddr[2] == fafc_pkg::REG_CAPACITY)) begin
            r_capacity <= pwdata[fafc_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == fafc_pkg::REG_CAPACITY)
                  ? {{(32 - fafc_pkg::CAP_W){1'b0}}, r_capacity} : 32'd0;

    fafc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_cmd          (cmd),
        .o_result_valid (o_result_valid)
    );

    fafc_dp #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key        (i_block_address[KEY_W-1:0]),
        .i_capacity   (r_capacity),
        .o_hit        (o_hit),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

endmodule

// File: rtl/fafc_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fafc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output fafc_pkg::t_dp_cmd o_cmd,
    output logic              o_result_valid
);

    fafc_pkg::t_state r_state, n_state;
    logic             r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fafc_pkg::S_IDLE: begin
                if (start) begin
                    n_state = fafc_pkg::S_MATCH;
                end
            end
            fafc_pkg::S_MATCH: begin
                n_state = fafc_pkg::S_UPDATE;
            end
            fafc_pkg::S_UPDATE: begin
                n_state = fafc_pkg::S_IDLE;
            end
            default: begin
                n_state = fafc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fafc_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == fafc_pkg::S_UPDATE);
        end
    end

    assign busy           = (r_state != fafc_pkg::S_IDLE);
    assign o_cmd.load     = (r_state == fafc_pkg::S_IDLE) && start;
    assign o_cmd.compare  = (r_state == fafc_pkg::S_MATCH);
    assign o_cmd.update   = (r_state == fafc_pkg::S_UPDATE);
    assign o_result_valid = r_done;

    `ASSERT_NEXT(a_accept_to_match, i_clk, i_rst_n, start && !busy, r_state == fafc_pkg::S_MATCH)
    `ASSERT_CLK(a_done_after_update, i_clk, i_rst_n, !r_done || $past(r_state == fafc_pkg::S_UPDATE))

endmodule

// File: rtl/fafc_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fafc_dp #(
    parameter int ENTRIES = 16,
    parameter int KEY_W   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fafc_pkg::t_dp_cmd           i_cmd,
    input  logic [KEY_W-1:0]            i_key,
    input  logic [fafc_pkg::CAP_W-1:0]  i_capacity,
    output logic                        o_hit,
    output logic [fafc_pkg::CNT_W-1:0]  o_hit_total,
    output logic [fafc_pkg::CNT_W-1:0]  o_miss_total
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]          r_key;
    logic [KEY_W-1:0]          r_entries [ENTRIES];
    logic [ENTRIES-1:0]        r_match;
    logic [FILL_W-1:0]         r_fill, n_fill;
    logic [IDX_W-1:0]          r_ptr, n_ptr;
    logic [fafc_pkg::CNT_W-1:0] r_hit_cnt, n_hit_cnt;
    logic [fafc_pkg::CNT_W-1:0] r_miss_cnt, n_miss_cnt;
    logic                      r_hit;

    logic [FILL_W-1:0] eff_cap;
    logic [FILL_W-1:0] ptr_ext, victim, victim_nx;
    logic              hit_now;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;

    // capacity 0 behaves as 1, anything above the built size as the built size
    always_comb begin
        if (32'(i_capacity) > 32'(ENTRIES)) begin
            eff_cap = FILL_W'(ENTRIES);
        end else if (i_capacity == '0) begin
            eff_cap = FILL_W'(1);
        end else begin
            eff_cap = FILL_W'(i_capacity);
        end
    end

    assign hit_now = |r_match;

    always_comb begin
        ptr_ext    = FILL_W'(r_ptr);
        victim     = (ptr_ext >= eff_cap) ? '0 : ptr_ext;
        victim_nx  = victim + FILL_W'(1);
        n_fill     = r_fill;
        n_ptr      = r_ptr;
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        wr_en      = 1'b0;
        wr_idx     = r_fill[IDX_W-1:0];
        if (i_cmd.update) begin
            if (hit_now) begin
                if (r_hit_cnt != fafc_pkg::CNT_MAX) begin
                    n_hit_cnt = r_hit_cnt + 32'd1;
                end
            end else begin
                if (r_miss_cnt != fafc_pkg::CNT_MAX) begin
                    n_miss_cnt = r_miss_cnt + 32'd1;
                end
                wr_en = 1'b1;
                if (r_fill < eff_cap) begin
                    n_fill = r_fill + FILL_W'(1);
                end else begin
                    wr_idx = victim[IDX_W-1:0];
                    n_ptr  = (victim_nx >= eff_cap) ? '0 : victim_nx[IDX_W-1:0];
                end
            end
        end
    end

    // tag store: each entry has its own comparator, written at one index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.compare) begin
                r_match[i] <= (FILL_W'(i) < r_fill) && (r_entries[i] == r_key);
            end
            if (wr_en && (wr_idx == IDX_W'(i))) begin
                r_entries[i] <= r_key;
            end
        end
        if (i_cmd.update) begin
            r_hit <= hit_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_ptr      <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else begin
            r_fill     <= n_fill;
            r_ptr      <= n_ptr;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    assign o_hit        = r_hit;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

    `ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, i_cmd.update && !hit_now && (r_fill < eff_cap), r_fill == $past(r_fill) + FILL_W'(1))
    `ASSERT_NEXT(a_hit_keeps_misses, i_clk, i_rst_n, i_cmd.update && hit_now, $stable(r_miss_cnt) && $stable(r_fill) && $stable(r_ptr))
    `ASSERT_NEXT(a_ptr_in_range, i_clk, i_rst_n, i_cmd.update && !hit_now && (r_fill >= eff_cap), FILL_W'(r_ptr) < $past(eff_cap))

endmodule
